// ----- rtl/tps_pkg.sv -----
`timescale 1ns / 1ps

package tps_pkg;

    // Input word: one add or report request
    typedef struct packed {
        logic        mode;
        logic [4:0]  task_count;
        logic [15:0] priority_req;
        logic [31:0] run_time;
    } t_in_word;

    // Output word: one result
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] task_id;
        logic [15:0] task_priority;
        logic [31:0] task_time;
        logic        last;
    } t_out_word;

    // Request modes
    localparam logic MODE_ADD    = 1'b0;
    localparam logic MODE_REPORT = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_CREATED = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_REPORT  = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    // Most tasks one add word may create
    localparam int         MAX_ADD   = 16;
    localparam logic [4:0] MAX_ADD_W = 5'd16;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // capture the input word
        logic emit;     // produce one result and update the table
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;   // output register can take a result this cycle
        logic last_step;  // the result being produced is the final one
        logic zero_add;   // incoming word is an add of zero tasks
    } t_dp_stat;

endpackage

// ----- rtl/tps_ctrl.sv -----
`timescale 1ns / 1ps

module tps_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  tps_pkg::t_dp_stat i_stat,
    output tps_pkg::t_dp_cmd  o_cmd,
    output logic              o_in_stall
);
    import tps_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.emit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (!i_stat.zero_add) begin
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.last_step) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ----- rtl/tps_datapath.sv -----
`timescale 1ns / 1ps

module tps_datapath #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tps_pkg::t_in_word  i_in,
    input  tps_pkg::t_dp_cmd   i_cmd,
    input  logic               i_out_stall,
    output tps_pkg::t_dp_stat  o_stat,
    output tps_pkg::t_out_word o_out,
    output logic               o_out_valid
);
    import tps_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int KMAX = (DEPTH > MAX_ADD) ? DEPTH : MAX_ADD;
    localparam int KW   = $clog2(KMAX + 1);

    // Sorted task table, one cell per entry, head at index 0
    logic [15:0] r_id   [DEPTH];
    logic [15:0] r_prio [DEPTH];
    logic [31:0] r_time [DEPTH];

    logic [CW-1:0] r_count;
    logic [15:0]   r_next_id;

    // Captured request
    logic          r_mode;
    logic [4:0]    r_num;
    logic [15:0]   r_prio_in;
    logic [31:0]   r_time_in;
    logic [KW-1:0] r_k;

    t_out_word     r_out;
    logic          r_out_valid;

    logic             out_free;
    logic             full;
    logic [KW-1:0]    total;
    logic             last_step;
    logic             do_insert;
    logic             do_rotate;
    logic [DEPTH-1:0] ins_here;   // new task goes at or before this cell

    // Priority descending, time ascending, id ascending
    function automatic logic goes_first(
        input logic [15:0] a_prio, input logic [31:0] a_time, input logic [15:0] a_id,
        input logic [15:0] b_prio, input logic [31:0] b_time, input logic [15:0] b_id
    );
        logic res;
        if (a_prio != b_prio) begin
            res = (a_prio > b_prio);
        end else if (a_time != b_time) begin
            res = (a_time < b_time);
        end else begin
            res = (a_id < b_id);
        end
        return res;
    endfunction

    // Step bookkeeping
    always_comb begin
        out_free  = !r_out_valid || !i_out_stall;
        full      = (r_count == CW'(DEPTH));
        if (r_mode == MODE_REPORT) begin
            total = (r_count == '0) ? KW'(1) : KW'(r_count);
        end else begin
            total = KW'(r_num);
        end
        last_step = ((r_k + KW'(1)) == total);
        do_insert = i_cmd.emit && (r_mode == MODE_ADD) && !full;
        do_rotate = i_cmd.emit && (r_mode == MODE_REPORT) && (r_count != '0);
    end

    // Insert position: every cell compares itself with the new task
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            ins_here[i] = (CW'(i) >= r_count) ||
                          goes_first(r_prio_in, r_time_in, r_next_id,
                                     r_prio[i], r_time[i], r_id[i]);
        end
    end

    // Table cells: insert shifts the tail down, report rotates the used part
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (do_insert) begin
                if (ins_here[i] && (i == 0 || !ins_here[(i == 0) ? 0 : i - 1])) begin
                    r_id[i]   <= r_next_id;
                    r_prio[i] <= r_prio_in;
                    r_time[i] <= r_time_in;
                end else if (ins_here[i] && i != 0) begin
                    r_id[i]   <= r_id[(i == 0) ? 0 : i - 1];
                    r_prio[i] <= r_prio[(i == 0) ? 0 : i - 1];
                    r_time[i] <= r_time[(i == 0) ? 0 : i - 1];
                end
            end else if (do_rotate) begin
                if (CW'(i) == r_count - CW'(1)) begin
                    r_id[i]   <= r_id[0];
                    r_prio[i] <= r_prio[0];
                    r_time[i] <= r_time[0];
                end else if (CW'(i) < r_count && i != DEPTH - 1) begin
                    r_id[i]   <= r_id[(i == DEPTH - 1) ? i : i + 1];
                    r_prio[i] <= r_prio[(i == DEPTH - 1) ? i : i + 1];
                    r_time[i] <= r_time[(i == DEPTH - 1) ? i : i + 1];
                end
            end
        end
    end

    // Table count and identifier counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_next_id <= 16'd1;
        end else if (do_insert) begin
            r_count <= r_count + CW'(1);
            if (r_next_id != 16'hFFFF) begin
                r_next_id <= r_next_id + 16'd1;
            end
        end
    end

    // Request capture and step counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode    <= i_in.mode;
            r_num     <= (i_in.task_count > MAX_ADD_W) ? MAX_ADD_W : i_in.task_count;
            r_prio_in <= i_in.priority_req;
            r_time_in <= i_in.run_time;
            r_k       <= '0;
        end else if (i_cmd.emit) begin
            r_k <= r_k + KW'(1);
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.last <= last_step;
            if (r_mode == MODE_ADD) begin
                if (full) begin
                    r_out.status        <= ST_FULL;
                    r_out.task_id       <= '0;
                    r_out.task_priority <= '0;
                    r_out.task_time     <= '0;
                end else begin
                    r_out.status        <= ST_CREATED;
                    r_out.task_id       <= r_next_id;
                    r_out.task_priority <= r_prio_in;
                    r_out.task_time     <= r_time_in;
                end
            end else if (r_count == '0) begin
                r_out.status        <= ST_EMPTY;
                r_out.task_id       <= '0;
                r_out.task_priority <= '0;
                r_out.task_time     <= '0;
            end else begin
                r_out.status        <= ST_REPORT;
                r_out.task_id       <= r_id[0];
                r_out.task_priority <= r_prio[0];
                r_out.task_time     <= r_time[0];
            end
        end
    end

    assign o_stat.out_free  = out_free;
    assign o_stat.last_step = last_step;
    assign o_stat.zero_add  = (i_in.mode == MODE_ADD) && (i_in.task_count == 5'd0);
    assign o_out            = r_out;
    assign o_out_valid      = r_out_valid;

    // Table never overfills
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("task table count above depth");

    // An insert grows the table by exactly one
    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_insert |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow table by one");

    // A report walk leaves the table size alone
    a_report_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_mode == MODE_REPORT) |=> $stable(r_count))
        else $error("report changed table count");

    // Identifier zero is never handed out
    a_id_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_id != 16'd0)
        else $error("identifier counter reached zero");

endmodule

// ----- rtl/task_priority_sorter.sv -----
`timescale 1ns / 1ps
// The word is captured in request registers; each result then enters the output register.
// Add word of n tasks (n clamped to 16): n results, one per unstalled cycle.
// Report word: max(entry count, 1) results, one per unstalled cycle; table rotates by one.
// Throughput: one result per unstalled cycle, single output register; next word after last.
// Reset (synchronous, active low): table empty, identifier counter at 1, no result held.
module task_priority_sorter #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tps_pkg::t_in_word  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tps_pkg::t_out_word o_out
);
    import tps_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer
    tps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Sorted table and result register
    tps_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out       (o_out),
        .o_out_valid (o_out_valid)
    );

endmodule

// ----- tb/task_priority_sorter_tb.sv -----
`timescale 1ns / 1ps

module task_priority_sorter_tb;
    import tps_pkg::*;

    localparam int DEPTH       = 16;
    localparam int GAP_MAX     = 5;
    localparam int HOLD_CYCLES = 150;
    localparam int N_RANDOM    = 100;
    localparam int DRAIN       = 24;
    localparam int N_PLAN      = 19;

    // One directed request, optionally with its single result typed in
    typedef struct packed {
        t_in_word  word;
        logic      typed;
        t_out_word result;
    } t_plan_row;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_word  in_word;
    logic      out_valid;
    logic      out_stall;
    t_out_word out_word;

    // Typed expectation travelling with the word on offer
    logic      row_typed;
    t_out_word row_result;

    // Sender / receiver coordination
    bit        quiet;
    bit        hold_req;

    t_plan_row plan [N_PLAN];

    // Shadow of the task table
    logic [15:0] table_id   [DEPTH];
    logic [15:0] table_prio [DEPTH];
    logic [31:0] table_time [DEPTH];
    int          stored;
    logic [15:0] id_counter;

    t_out_word due_results[$];
    t_out_word fresh_results[$];

    int errors;
    int words_sent;
    int results_seen;
    int report_entries;
    int dropped;

    task_priority_sorter #(.DEPTH(DEPTH)) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_word)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic t_in_word request_word(input logic mode, input logic [4:0] count,
                                              input logic [15:0] prio, input logic [31:0] t);
        t_in_word w;
        w.mode         = mode;
        w.task_count   = count;
        w.priority_req = prio;
        w.run_time     = t;
        return w;
    endfunction

    function automatic t_out_word result_word(input logic [1:0] status, input logic [15:0] id,
                                              input logic [15:0] prio, input logic [31:0] t,
                                              input logic last);
        t_out_word r;
        r.status        = status;
        r.task_id       = id;
        r.task_priority = prio;
        r.task_time     = t;
        r.last          = last;
        return r;
    endfunction

    // Sort order: priority high first, then shorter time, then lower ID
    function automatic bit ranks_ahead(input logic [15:0] pa, input logic [31:0] ta,
                                       input logic [15:0] ia, input logic [15:0] pb,
                                       input logic [31:0] tb, input logic [15:0] ib);
        if (pa != pb)
            return pa > pb;
        if (ta != tb)
            return ta < tb;
        return ia < ib;
    endfunction

    // Update the shadow table for one accepted word; results land in fresh_results
    task automatic apply_request(input t_in_word w);
        logic [15:0] s_id   [DEPTH];
        logic [15:0] s_prio [DEPTH];
        logic [31:0] s_time [DEPTH];
        int          n;
        int          j;
        fresh_results.delete();
        if (w.mode == MODE_ADD) begin
            n = (w.task_count > MAX_ADD_W) ? MAX_ADD : int'(w.task_count);
            for (int k = 0; k < n; k++) begin
                if (stored < DEPTH) begin
                    table_id[stored]   = id_counter;
                    table_prio[stored] = w.priority_req;
                    table_time[stored] = w.run_time;
                    stored++;
                    fresh_results.push_back(result_word(ST_CREATED, id_counter,
                                            w.priority_req, w.run_time, k == n - 1));
                    if (id_counter != 16'hFFFF)
                        id_counter++;
                end else begin
                    fresh_results.push_back(result_word(ST_FULL, '0, '0, '0, k == n - 1));
                end
            end
        end else if (stored == 0) begin
            fresh_results.push_back(result_word(ST_EMPTY, '0, '0, '0, 1'b1));
        end else begin
            // insertion sort of the stored entries
            for (int i = 0; i < stored; i++) begin
                j = i;
                while (j > 0 && ranks_ahead(table_prio[i], table_time[i], table_id[i],
                                            s_prio[j-1], s_time[j-1], s_id[j-1])) begin
                    s_id[j]   = s_id[j-1];
                    s_prio[j] = s_prio[j-1];
                    s_time[j] = s_time[j-1];
                    j--;
                end
                s_id[j]   = table_id[i];
                s_prio[j] = table_prio[i];
                s_time[j] = table_time[i];
            end
            for (int i = 0; i < stored; i++)
                fresh_results.push_back(result_word(ST_REPORT, s_id[i], s_prio[i], s_time[i],
                                        i == stored - 1));
        end
    endtask

    // Compare one accepted result against the oldest one due
    task automatic check_result(input t_out_word got);
        t_out_word want;
        results_seen++;
        if (got.status == ST_REPORT)
            report_entries++;
        if (got.status == ST_FULL)
            dropped++;
        if (due_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
        end else begin
            want = due_results.pop_front();
            if (got.status !== want.status || got.task_id !== want.task_id ||
                got.task_priority !== want.task_priority ||
                got.task_time !== want.task_time || got.last !== want.last) begin
                errors++;
                $display("%0t: expected %0d/%0d/%h/%h/%b, actual %0d/%0d/%h/%h/%b",
                         $time, want.status, want.task_id, want.task_priority,
                         want.task_time, want.last, got.status, got.task_id,
                         got.task_priority, got.task_time, got.last);
            end
        end
    endtask

    // Handshake monitor: both channels sampled at the rising edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                apply_request(in_word);
                if (row_typed)
                    due_results.push_back(row_result);
                else
                    foreach (fresh_results[i])
                        due_results.push_back(fresh_results[i]);
            end
            if (out_valid && !out_stall)
                check_result(out_word);
        end
    end

    // Offer one word after a random gap and hold it until taken
    task automatic send_word(input t_in_word w, input logic typed, input t_out_word r);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_word    <= w;
        row_typed  <= typed;
        row_result <= r;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    // Receiver: random stall per result, one long hold-off on request
    initial begin
        int wait_cycles;
        out_stall = 1'b1;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            wait_cycles = quiet ? 0 : $urandom_range(0, GAP_MAX);
            if (hold_req) begin
                hold_req    = 1'b0;
                wait_cycles = HOLD_CYCLES;
            end
            if (wait_cycles > 0) begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // Directed requests: fill the table in steps, reporting in between
    task automatic build_plan();
        t_out_word none;
        none = '0;
        plan[0]  = '{request_word(MODE_REPORT, 5'd0, 16'h0, 32'h0), 1'b1,
                     result_word(ST_EMPTY, '0, '0, '0, 1'b1)};
        plan[1]  = '{request_word(MODE_ADD, 5'd0, 16'h7777, 32'h1), 1'b0, none};
        plan[2]  = '{request_word(MODE_ADD, 5'd1, 16'hFFFF, 32'hFFFF_FFFF), 1'b1,
                     result_word(ST_CREATED, 16'd1, 16'hFFFF, 32'hFFFF_FFFF, 1'b1)};
        plan[3]  = '{request_word(MODE_REPORT, 5'd31, 16'hFFFF, 32'hFFFF_FFFF), 1'b1,
                     result_word(ST_REPORT, 16'd1, 16'hFFFF, 32'hFFFF_FFFF, 1'b1)};
        plan[4]  = '{request_word(MODE_ADD, 5'd1, 16'h0, 32'h0), 1'b1,
                     result_word(ST_CREATED, 16'd2, 16'h0, 32'h0, 1'b1)};
        plan[5]  = '{request_word(MODE_ADD, 5'd3, 16'd100, 32'd500), 1'b0, none};
        plan[6]  = '{request_word(MODE_ADD, 5'd2, 16'd100, 32'd20), 1'b0, none};
        plan[7]  = '{request_word(MODE_REPORT, 5'd0, 16'h0, 32'h0), 1'b0, none};
        plan[8]  = '{request_word(MODE_ADD, 5'd2, 16'h0, 32'h0), 1'b0, none};
        plan[9]  = '{request_word(MODE_ADD, 5'd1, 16'hFFFF, 32'h0), 1'b0, none};
        plan[10] = '{request_word(MODE_REPORT, 5'd16, 16'h5555, 32'hAAAA_AAAA), 1'b0, none};
        // count above the clamp, and the table overflows partway
        plan[11] = '{request_word(MODE_ADD, 5'd31, 16'h1234, 32'hDEAD_BEEF), 1'b0, none};
        plan[12] = '{request_word(MODE_REPORT, 5'd0, 16'h0, 32'h0), 1'b0, none};
        plan[13] = '{request_word(MODE_ADD, 5'd1, 16'd5, 32'd5), 1'b1,
                     result_word(ST_FULL, '0, '0, '0, 1'b1)};
        plan[14] = '{request_word(MODE_ADD, 5'd17, 16'hABCD, 32'h1234_5678), 1'b0, none};
        plan[15] = '{request_word(MODE_ADD, 5'd16, 16'hFFFF, 32'h0), 1'b0, none};
        plan[16] = '{request_word(MODE_REPORT, 5'd1, 16'h0, 32'h0), 1'b0, none};
        plan[17] = '{request_word(MODE_ADD, 5'd0, 16'hFFFF, 32'hFFFF_FFFF), 1'b0, none};
        plan[18] = '{request_word(MODE_REPORT, 5'd8, 16'h00FF, 32'h0F0F_0F0F), 1'b0, none};
    endtask

    // Main sequence
    initial begin
        t_in_word w;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_word    = '0;
        row_typed  = 1'b0;
        row_result = '0;
        quiet      = 1'b0;
        hold_req   = 1'b0;
        stored     = 0;
        id_counter = 16'd1;
        errors     = 0;
        words_sent = 0;
        results_seen   = 0;
        report_entries = 0;
        dropped        = 0;
        build_plan();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_PLAN; i++)
            send_word(plan[i].word, plan[i].typed, plan[i].result);

        for (int k = 0; k < N_RANDOM; k++) begin
            if (k == 10)
                hold_req = 1'b1;
            quiet = (k >= 30 && k < 45);
            // let the block drain completely once
            if (k == 60) begin
                in_valid <= 1'b0;
                @(negedge clk);
                while (due_results.size() != 0)
                    @(negedge clk);
            end
            w = request_word($urandom_range(0, 1) ? MODE_REPORT : MODE_ADD,
                             5'($urandom_range(0, 31)), 16'($urandom), 32'($urandom));
            send_word(w, 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("Sent %0d request words (directed fills, clamped adds, empty and full table)",
                 words_sent);
        $display("Checked %0d results: %0d sorted report entries, %0d dropped on full table",
                 results_seen, report_entries, dropped);
        if (errors == 0) begin
            $display("task_priority_sorter verification clean");
        end else begin
            $display("task_priority_sorter verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("task_priority_sorter verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/tps_pkg.sv
rtl/tps_ctrl.sv
rtl/tps_datapath.sv
rtl/task_priority_sorter.sv
tb/task_priority_sorter_tb.sv
